// File: sv/cbdr_pkg.sv
// Shared types, constants and the CRC byte update for the block deframer.
package cbdr_pkg;

   localparam int MAX_FRAME_DEF = 64;
   localparam int MIN_FRAME     = 5;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h8408;
   localparam logic [7:0]  SEQ_MASK = 8'h0F;

   localparam logic [0:0] CSR_SYNC_VALUE = 1'b0;
   localparam logic [0:0] CSR_DEST_BITS  = 1'b1;

   localparam logic [2:0] RD_IDX   = 3'd0;
   localparam logic [2:0] RD_ZERO  = 3'd1;
   localparam logic [2:0] RD_ONE   = 3'd2;
   localparam logic [2:0] RD_LENM1 = 3'd3;
   localparam logic [2:0] RD_LENM3 = 3'd4;
   localparam logic [2:0] RD_LENM2 = 3'd5;

   typedef struct packed {
      logic       append;
      logic       rd_en;
      logic [2:0] rd_sel;
      logic       ld_len;
      logic       ld_seq;
      logic       crc_init;
      logic       crc_step;
      logic       idx_clr;
      logic       idx_inc;
      logic       ld_rxhi;
      logic       ev_good;
      logic       ev_disc_idx;
      logic       ev_disc_all;
      logic       emit_last;
   } cmd_type;

   typedef struct packed {
      logic held_lt_min;
      logic hunting;
      logic len_bad;
      logic dest_bad;
      logic held_lt_len;
      logic byte_is_sync;
      logic crc_last;
      logic srch_last;
      logic crc_ok;
      logic pend_valid;
      logic out_free;
   } stat_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// File: sv/cbdr_ram.sv
// Generic single write, single read RAM with registered read data.
module cbdr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: sv/cbdr_ctrl.sv
// Controller state machine that sequences the parse of the held bytes.
module cbdr_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  cbdr_pkg::stat_type stat,
   output cbdr_pkg::cmd_type  cmd
);
   import cbdr_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_PARSE    = 4'd1;
   localparam logic [3:0] S_LEN_CHK  = 4'd2;
   localparam logic [3:0] S_DEST_CHK = 4'd3;
   localparam logic [3:0] S_SYNC_CHK = 4'd4;
   localparam logic [3:0] S_CRC_RD   = 4'd5;
   localparam logic [3:0] S_CRC_UPD  = 4'd6;
   localparam logic [3:0] S_RX_HI    = 4'd7;
   localparam logic [3:0] S_RX_LO    = 4'd8;
   localparam logic [3:0] S_GOOD     = 4'd9;
   localparam logic [3:0] S_SRCH_RD  = 4'd10;
   localparam logic [3:0] S_SRCH_CHK = 4'd11;
   localparam logic [3:0] S_DISC_IDX = 4'd12;
   localparam logic [3:0] S_DISC_ALL = 4'd13;
   localparam logic [3:0] S_FLUSH    = 4'd14;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       ev_ok;

   assign req_stall = (state_ff != S_IDLE);
   assign ev_ok     = !stat.pend_valid || stat.out_free;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.append = 1'b1;
               state_in   = S_PARSE;
            end
         end
         S_PARSE: begin
            if (stat.held_lt_min) begin
               state_in = S_FLUSH;
            end else if (stat.hunting) begin
               cmd.idx_clr = 1'b1;
               state_in    = S_SRCH_RD;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_ZERO;
               state_in   = S_LEN_CHK;
            end
         end
         S_LEN_CHK: begin
            cmd.ld_len = 1'b1;
            if (stat.len_bad) begin
               cmd.idx_clr = 1'b1;
               state_in    = S_SRCH_RD;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_ONE;
               state_in   = S_DEST_CHK;
            end
         end
         S_DEST_CHK: begin
            cmd.ld_seq = 1'b1;
            if (stat.dest_bad) begin
               cmd.idx_clr = 1'b1;
               state_in    = S_SRCH_RD;
            end else if (stat.held_lt_len) begin
               state_in = S_FLUSH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_LENM1;
               state_in   = S_SYNC_CHK;
            end
         end
         S_SYNC_CHK: begin
            cmd.idx_clr = 1'b1;
            if (!stat.byte_is_sync) begin
               state_in = S_SRCH_RD;
            end else begin
               cmd.crc_init = 1'b1;
               state_in     = S_CRC_RD;
            end
         end
         S_CRC_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_IDX;
            state_in   = S_CRC_UPD;
         end
         S_CRC_UPD: begin
            cmd.crc_step = 1'b1;
            cmd.idx_inc  = 1'b1;
            if (stat.crc_last) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_LENM3;
               state_in   = S_RX_HI;
            end else begin
               state_in = S_CRC_RD;
            end
         end
         S_RX_HI: begin
            cmd.ld_rxhi = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = RD_LENM2;
            state_in    = S_RX_LO;
         end
         S_RX_LO: begin
            if (stat.crc_ok) begin
               state_in = S_GOOD;
            end else begin
               cmd.idx_clr = 1'b1;
               state_in    = S_SRCH_RD;
            end
         end
         S_GOOD: begin
            if (ev_ok) begin
               cmd.ev_good = 1'b1;
               state_in    = S_PARSE;
            end
         end
         S_SRCH_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_IDX;
            state_in   = S_SRCH_CHK;
         end
         S_SRCH_CHK: begin
            if (stat.byte_is_sync) begin
               state_in = S_DISC_IDX;
            end else if (stat.srch_last) begin
               state_in = S_DISC_ALL;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_SRCH_RD;
            end
         end
         S_DISC_IDX: begin
            if (ev_ok) begin
               cmd.ev_disc_idx = 1'b1;
               state_in        = S_PARSE;
            end
         end
         S_DISC_ALL: begin
            if (ev_ok) begin
               cmd.ev_disc_all = 1'b1;
               state_in        = S_PARSE;
            end
         end
         S_FLUSH: begin
            if (!stat.pend_valid) begin
               state_in = S_IDLE;
            end else if (stat.out_free) begin
               cmd.emit_last = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// File: sv/cbdr_dpath.sv
// Datapath: frame store, pointers, CRC, configuration and result registers.
module cbdr_dpath #(
   parameter int MAX_FRAME = cbdr_pkg::MAX_FRAME_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [0:0]                     csr_index,
   input  logic [7:0]                     csr_wdata,
   input  logic [7:0]                     req_data_byte,
   input  cbdr_pkg::cmd_type              cmd,
   output cbdr_pkg::stat_type             stat,
   input  logic                           rsp_stall,
   output logic                           rsp_valid,
   output logic                           rsp_event_kind,
   output logic [$clog2(MAX_FRAME+1)-1:0] rsp_byte_count,
   output logic [3:0]                     rsp_seq_number,
   output logic                           rsp_last_event
);
   import cbdr_pkg::*;

   localparam int CW = $clog2(MAX_FRAME + 1);
   localparam int AW = $clog2(MAX_FRAME);

   logic [7:0]    sync_ff, dest_ff;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] held_ff, held_in;
   logic          hunt_ff, hunt_in;
   logic [CW-1:0] len_ff, idx_ff;
   logic [3:0]    seq_ff;
   logic [15:0]   crc_ff;
   logic [7:0]    rxhi_ff;
   logic          pend_valid_ff, pend_valid_in;
   logic          pend_kind_ff;
   logic [CW-1:0] pend_cnt_ff;
   logic [3:0]    pend_seq_ff;
   logic          out_valid_ff, out_valid_in;
   logic          out_kind_ff;
   logic [CW-1:0] out_cnt_ff;
   logic [3:0]    out_seq_ff;
   logic          out_last_ff;
   logic [CW-1:0] rd_off;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [7:0]    rd_data;
   logic          ev_any, ev_kind, load_out;
   logic [CW-1:0] ev_cnt;
   logic [3:0]    ev_seq;
   logic [8:0]    rd9;

   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
      logic [CW:0] sum;
      sum = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, off};
      if (sum >= (CW + 1)'(MAX_FRAME)) begin
         sum = sum - (CW + 1)'(MAX_FRAME);
      end
      return sum[AW-1:0];
   endfunction

   always_comb begin
      unique case (cmd.rd_sel)
         RD_IDX:   rd_off = idx_ff;
         RD_ZERO:  rd_off = '0;
         RD_ONE:   rd_off = CW'(1);
         RD_LENM1: rd_off = len_ff - CW'(1);
         RD_LENM3: rd_off = len_ff - CW'(3);
         RD_LENM2: rd_off = len_ff - CW'(2);
         default:  rd_off = '0;
      endcase
   end

   assign rd_addr = wrap_add(head_ff, rd_off);
   assign wr_addr = wrap_add(head_ff, held_ff);

   cbdr_ram #(.WIDTH(8), .DEPTH(MAX_FRAME)) u_store (
      .clock   (clock),
      .wr_en   (cmd.append),
      .wr_addr (wr_addr),
      .wr_data (req_data_byte),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd9 = {1'b0, rd_data};

   always_comb begin
      stat.held_lt_min  = held_ff < CW'(MIN_FRAME);
      stat.hunting      = hunt_ff;
      stat.len_bad      = (rd9 < 9'(MIN_FRAME)) || (rd9 > 9'(MAX_FRAME));
      stat.dest_bad     = (rd_data & ~SEQ_MASK) != dest_ff;
      stat.held_lt_len  = held_ff < len_ff;
      stat.byte_is_sync = rd_data == sync_ff;
      stat.crc_last     = idx_ff == (len_ff - CW'(4));
      stat.srch_last    = idx_ff == (held_ff - CW'(1));
      stat.crc_ok       = {rxhi_ff, rd_data} == crc_ff;
      stat.pend_valid   = pend_valid_ff;
      stat.out_free     = !out_valid_ff || !rsp_stall;
   end

   always_comb begin
      ev_any  = cmd.ev_good || cmd.ev_disc_idx || cmd.ev_disc_all;
      ev_kind = !cmd.ev_good;
      ev_seq  = cmd.ev_good ? seq_ff : 4'd0;
      priority if (cmd.ev_good) begin
         ev_cnt = len_ff;
      end else if (cmd.ev_disc_idx) begin
         ev_cnt = idx_ff + CW'(1);
      end else begin
         ev_cnt = held_ff;
      end

      head_in = head_ff;
      held_in = held_ff;
      hunt_in = hunt_ff;
      if (cmd.append) begin
         held_in = held_ff + CW'(1);
      end
      if (ev_any) begin
         head_in = wrap_add(head_ff, ev_cnt);
         held_in = held_ff - ev_cnt;
         if (cmd.ev_disc_idx) begin
            hunt_in = 1'b0;
         end else if (cmd.ev_disc_all) begin
            hunt_in = 1'b1;
         end
      end

      load_out      = (ev_any && pend_valid_ff) || cmd.emit_last;
      pend_valid_in = pend_valid_ff;
      if (ev_any) begin
         pend_valid_in = 1'b1;
      end else if (cmd.emit_last) begin
         pend_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff && rsp_stall;
      if (load_out) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff       <= 8'd126;
         dest_ff       <= 8'd16;
         head_ff       <= '0;
         held_ff       <= '0;
         hunt_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_SYNC_VALUE: sync_ff <= csr_wdata;
               CSR_DEST_BITS:  dest_ff <= csr_wdata;
               default:        sync_ff <= sync_ff;
            endcase
         end
         head_ff       <= head_in;
         held_ff       <= held_in;
         hunt_ff       <= hunt_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ld_len) begin
         len_ff <= CW'(rd_data);
      end
      if (cmd.ld_seq) begin
         seq_ff <= rd_data[3:0];
      end
      if (cmd.ld_rxhi) begin
         rxhi_ff <= rd_data;
      end
      if (cmd.crc_init) begin
         crc_ff <= CRC_INIT;
      end else if (cmd.crc_step) begin
         crc_ff <= crc_byte(crc_ff, rd_data);
      end
      if (cmd.idx_clr) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + CW'(1);
      end
      if (ev_any) begin
         pend_kind_ff <= ev_kind;
         pend_cnt_ff  <= ev_cnt;
         pend_seq_ff  <= ev_seq;
      end
      if (load_out) begin
         out_kind_ff <= pend_kind_ff;
         out_cnt_ff  <= pend_cnt_ff;
         out_seq_ff  <= pend_seq_ff;
         out_last_ff <= cmd.emit_last;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_event_kind = out_kind_ff;
   assign rsp_byte_count = out_cnt_ff;
   assign rsp_seq_number = out_seq_ff;
   assign rsp_last_event = out_last_ff;
endmodule

// File: sv/crc16_block_deframer_resync.sv
// Top level of the length-framed block deframer with CRC check and resync.
//
//   Channel  Direction  Handshake          Content
//   req      in         req_valid/stall    one received link byte
//   rsp      out        rsp_valid/stall    one frame or discard event
//   csr      in         csr_write          sync value and destination bits
//
// One byte is taken at a time; the next is accepted once every event it
// causes has been placed in the result register or the one-entry hold stage.
// Each frame store read is registered, so the parser spends a read state and a
// check state on every byte it examines in a CRC pass or a sync search.
// Reset clears the pointers, counts and hunting flag; the store is not cleared.
// A stalled result holds the parser at the point where it next reports.
module crc16_block_deframer_resync #(
   parameter int MAX_FRAME = cbdr_pkg::MAX_FRAME_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [0:0]                     csr_index,
   input  logic [7:0]                     csr_wdata,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_data_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_event_kind,
   output logic [$clog2(MAX_FRAME+1)-1:0] rsp_byte_count,
   output logic [3:0]                     rsp_seq_number,
   output logic                           rsp_last_event
);
   import cbdr_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   cbdr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   cbdr_dpath #(.MAX_FRAME(MAX_FRAME)) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_data_byte  (req_data_byte),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_event_kind (rsp_event_kind),
      .rsp_byte_count (rsp_byte_count),
      .rsp_seq_number (rsp_seq_number),
      .rsp_last_event (rsp_last_event)
   );
endmodule

// File: sv/cbdr_checker.sv
// Port-level checker for the block deframer and its bind statement.
module cbdr_checker #(
   parameter int MAX_FRAME = cbdr_pkg::MAX_FRAME_DEF
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic                           rsp_event_kind,
   input logic [$clog2(MAX_FRAME+1)-1:0] rsp_byte_count,
   input logic [3:0]                     rsp_seq_number
);
   import cbdr_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("Stalled result transaction was withdrawn.");

   a_good_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_event_kind |-> rsp_byte_count >= MIN_FRAME)
      else $error("Good frame shorter than the minimum length.");

   a_disc_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind |-> rsp_seq_number == 4'd0)
      else $error("Discard transaction carries a sequence number.");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("Input accepted again before the previous byte was parsed.");
endmodule

bind crc16_block_deframer_resync cbdr_checker #(.MAX_FRAME(MAX_FRAME)) u_cbdr_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_event_kind (rsp_event_kind),
   .rsp_byte_count (rsp_byte_count),
   .rsp_seq_number (rsp_seq_number)
);

// File: sim/crc16_block_deframer_resync_tb.sv
// Self-checking testbench for the block deframer: directed rows, then random frames.
module crc16_block_deframer_resync_tb;
   import cbdr_pkg::*;

   localparam int STORE_DEPTH = 64;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE      = 200;
   localparam int ITEM_GOAL   = 420;

   typedef struct {
      logic       kind;
      logic [6:0] count;
      logic [3:0] seq;
      logic       last;
   } frame_event_type;

   typedef enum {SRC_LIT, SRC_CRC_HI, SRC_CRC_LO} byte_src_type;

   typedef struct {
      byte_src_type src;
      logic [7:0]   val;
      bit           chk;
      int           n_ev;
      logic         kind;
      int           count;
      int           seq;
   } dir_row_type;

   logic       clock = 0;
   logic       reset = 1;
   logic       csr_write = 0;
   logic [0:0] csr_index = '0;
   logic [7:0] csr_wdata = '0;
   logic       req_valid = 0;
   logic       req_stall;
   logic [7:0] req_data_byte = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1;
   logic       rsp_event_kind;
   logic [6:0] rsp_byte_count;
   logic [3:0] rsp_seq_number;
   logic       rsp_last_event;

   logic [7:0] link_store [STORE_DEPTH];
   int         held;
   bit         hunting;
   logic [7:0] sync_byte;
   logic [7:0] dest_field;

   frame_event_type pending_events[$];
   bit              failed = 0;
   int              cycles = 0;
   int              bytes_sent = 0;
   bit              calm_rx = 0;

   crc16_block_deframer_resync dut (.*);

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic logic [15:0] mcrf_crc(int n);
      logic [15:0] c;
      c = 16'hFFFF;
      for (int i = 0; i < n; i++) begin
         c ^= {8'h00, link_store[i]};
         for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
         end
      end
      return c;
   endfunction

   // Positive: good frame of that length; negative: discard; zero: wait for more.
   function automatic int parse_store();
      int len;
      if (held < MIN_FRAME) return 0;
      if (!hunting) begin
         len = int'(link_store[0]);
         if (len >= MIN_FRAME && len <= STORE_DEPTH && (link_store[1] & 8'hF0) == dest_field)
         begin
            if (held < len) return 0;
            if (link_store[len-1] == sync_byte &&
                mcrf_crc(len - 3) == {link_store[len-3], link_store[len-2]}) return len;
         end
      end
      for (int i = 0; i < held; i++) begin
         if (link_store[i] == sync_byte) begin
            hunting = 0;
            return -(i + 1);
         end
      end
      hunting = 1;
      return -held;
   endfunction

   function automatic void predict_events(logic [7:0] b);
      int r;
      int n;
      int made;
      frame_event_type ev;
      made = 0;
      if (held < STORE_DEPTH) begin
         link_store[held] = b;
         held++;
      end
      forever begin
         r = parse_store();
         if (r == 0 || made >= STORE_DEPTH) break;
         n = (r > 0) ? r : -r;
         ev.kind  = (r < 0);
         ev.count = n[6:0];
         ev.seq   = (r > 0) ? link_store[1][3:0] : 4'h0;
         ev.last  = 0;
         pending_events.push_back(ev);
         for (int i = 0; i + n < held; i++) link_store[i] = link_store[i+n];
         held = (n >= held) ? 0 : held - n;
         made++;
      end
      if (made > 0) pending_events[pending_events.size()-1].last = 1;
   endfunction

   always @(posedge clock) begin
      frame_event_type ev;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_events.size() == 0) begin
            $error("unexpected event kind=%0d count=%0d", rsp_event_kind, rsp_byte_count);
            failed = 1;
         end else begin
            ev = pending_events.pop_front();
            if (rsp_event_kind !== ev.kind) begin
               $error("event_kind expected %0d actual %0d", ev.kind, rsp_event_kind);
               failed = 1;
            end
            if (rsp_byte_count !== ev.count) begin
               $error("byte_count expected %0d actual %0d", ev.count, rsp_byte_count);
               failed = 1;
            end
            if (rsp_seq_number !== ev.seq) begin
               $error("seq_number expected %0d actual %0d", ev.seq, rsp_seq_number);
               failed = 1;
            end
            if (rsp_last_event !== ev.last) begin
               $error("last_event expected %0d actual %0d", ev.last, rsp_last_event);
               failed = 1;
            end
         end
      end
   end

   initial begin
      int n;
      @(negedge reset);
      forever begin
         n = (calm_rx || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
         if (n > 0) begin
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_byte(logic [7:0] b, bit calm);
      int gap;
      gap = (calm || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall);
      predict_events(b);
      bytes_sent++;
   endtask

   task automatic write_reg(logic [0:0] idx, logic [7:0] val);
      req_valid <= 0;
      wait (pending_events.size() == 0);
      repeat (SETTLE) @(posedge clock);
      csr_write <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 0;
      if (idx == CSR_SYNC_VALUE) sync_byte = val;
      else dest_field = val;
   endtask

   task automatic send_frame(bit calm);
      logic [7:0] fr [STORE_DEPTH];
      logic [15:0] c;
      int len;
      int fault;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 64) : $urandom_range(5, 12);
      fr[0] = 8'(len);
      fr[1] = dest_field | 8'($urandom_range(0, 15));
      for (int i = 2; i < len - 3; i++) fr[i] = 8'($urandom_range(0, 255));
      c = 16'hFFFF;
      for (int i = 0; i < len - 3; i++) begin
         c ^= {8'h00, fr[i]};
         for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
      end
      fr[len-3] = c[15:8];
      fr[len-2] = c[7:0];
      fr[len-1] = sync_byte;
      fault = $urandom_range(0, 9);
      case (fault)
         0: fr[len - 1 - $urandom_range(1, 2)] ^= 8'h01 << $urandom_range(0, 7);
         1: fr[len-1] = sync_byte ^ 8'h80;
         2: fr[0] = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 4))
                                                 : 8'($urandom_range(65, 255));
         3: fr[1] ^= 8'h10 << $urandom_range(0, 3);
         default: ;
      endcase
      for (int i = 0; i < len; i++) send_byte(fr[i], calm);
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)), calm);
      end
   endtask

   dir_row_type dir_rows [] = '{
      '{SRC_LIT,    8'h05, 1, 0, 0, 0, 0},
      '{SRC_LIT,    8'h1F, 0, 0, 0, 0, 0},
      '{SRC_CRC_HI, 8'h00, 0, 0, 0, 0, 0},
      '{SRC_CRC_LO, 8'h00, 0, 0, 0, 0, 0},
      '{SRC_LIT,    8'h7E, 1, 1, 0, 5, 15},
      '{SRC_LIT,    8'h00, 0, 0, 0, 0, 0},
      '{SRC_LIT,    8'h00, 0, 0, 0, 0, 0},
      '{SRC_LIT,    8'h00, 0, 0, 0, 0, 0},
      '{SRC_LIT,    8'h00, 0, 0, 0, 0, 0},
      '{SRC_LIT,    8'hFF, 1, 1, 1, 5, 0},
      '{SRC_LIT,    8'h7E, 0, 0, 0, 0, 0},
      '{SRC_LIT,    8'h01, 0, 0, 0, 0, 0},
      '{SRC_LIT,    8'h02, 0, 0, 0, 0, 0},
      '{SRC_LIT,    8'h03, 1, 0, 0, 0, 0},
      '{SRC_LIT,    8'h04, 1, 1, 1, 1, 0},
      '{SRC_LIT,    8'h05, 1, 1, 1, 5, 0},
      '{SRC_LIT,    8'h40, 0, 0, 0, 0, 0},
      '{SRC_LIT,    8'h10, 0, 0, 0, 0, 0},
      '{SRC_LIT,    8'h00, 0, 0, 0, 0, 0},
      '{SRC_LIT,    8'h00, 0, 0, 0, 0, 0},
      '{SRC_LIT,    8'h7E, 1, 1, 1, 5, 0}
   };

   initial begin
      logic [7:0] b;
      logic [15:0] c;
      int before_n;
      int phase;
      bit drained;
      frame_event_type ev;
      held = 0;
      hunting = 0;
      drained = 0;
      sync_byte = 8'h7E;
      dest_field = 8'h10;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         // Both check bytes cover the bytes held before the high byte was appended.
         c = mcrf_crc((dir_rows[i].src == SRC_CRC_LO) ? held - 1 : held);
         case (dir_rows[i].src)
            SRC_CRC_HI: b = c[15:8];
            SRC_CRC_LO: b = c[7:0];
            default:    b = dir_rows[i].val;
         endcase
         before_n = pending_events.size();
         send_byte(b, 0);
         if (dir_rows[i].chk) begin
            if (pending_events.size() - before_n != dir_rows[i].n_ev) begin
               $error("row %0d event total expected %0d actual %0d", i, dir_rows[i].n_ev,
                      pending_events.size() - before_n);
               failed = 1;
            end else if (dir_rows[i].n_ev > 0) begin
               ev = pending_events[pending_events.size()-1];
               if (ev.kind !== dir_rows[i].kind || ev.count != dir_rows[i].count ||
                   ev.seq != dir_rows[i].seq) begin
                  $error("row %0d kind/count/seq expected %0d/%0d/%0d actual %0d/%0d/%0d", i,
                         dir_rows[i].kind, dir_rows[i].count, dir_rows[i].seq,
                         ev.kind, ev.count, ev.seq);
                  failed = 1;
               end
            end
         end
      end

      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            1: begin write_reg(CSR_SYNC_VALUE, 8'h00); write_reg(CSR_DEST_BITS, 8'hF0); end
            2: begin write_reg(CSR_SYNC_VALUE, 8'hFF); write_reg(CSR_DEST_BITS, 8'h00); end
            3: begin write_reg(CSR_SYNC_VALUE, 8'h5A); write_reg(CSR_DEST_BITS, 8'h1F); end
            4: begin write_reg(CSR_SYNC_VALUE, 8'h7E); write_reg(CSR_DEST_BITS, 8'h10); end
            default: ;
         endcase
         calm_rx = (phase == 2);
         while (bytes_sent < (phase + 1) * ITEM_GOAL / 5 + dir_rows.size()) begin
            if ($urandom_range(0, 5) == 0) send_byte(8'($urandom_range(0, 255)), phase == 4);
            else send_frame(phase == 4);
            if (phase == 1 && !drained && bytes_sent > ITEM_GOAL / 3) begin
               drained = 1;
               req_valid <= 0;
               wait (pending_events.size() == 0);
            end
         end
      end

      req_valid <= 0;
      wait (pending_events.size() == 0);
      repeat (SETTLE) @(posedge clock);
      if (!failed && pending_events.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
